// ===== hdl/mfd_pkg.sv =====
// shared types, codes and width limits for the max-flow engine
package mfd_pkg;

  localparam int N_MAX  = 10;
  localparam int S_MAX  = 14;
  localparam int L_MAX  = 15;
  localparam int C_MAX  = 29;
  localparam int LV_MAX = 10;

  localparam int FLOW_BITS = 24;
  localparam logic [FLOW_BITS-1:0] FLOW_MAX = 24'hFFFFFF;

  localparam logic [1:0] REQ_CLEAR = 2'd0;
  localparam logic [1:0] REQ_ADD   = 2'd1;
  localparam logic [1:0] REQ_RUN   = 2'd2;

  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_FULL = 2'd1;
  localparam logic [1:0] ST_SAME = 2'd2;

  typedef enum logic [4:0] {
    S_IDLE, S_DEC, S_ADD_A, S_ADD_B, S_ADD_C,
    S_B_INIT, S_B_POP, S_B_POPW, S_B_HEAD, S_B_EDGE, S_B_EDGEW,
    S_F_INIT, S_F_TOP, S_F_ARC, S_F_ARCW, S_N_CHK, S_N_W, S_N_W2, S_N_RES,
    S_P_RD, S_P_RDW, S_P_CMP, S_Q_RD, S_Q_W1, S_Q_W2, S_Q_W3,
    S_E_RD, S_E_W1, S_E_W2, S_DONE
  } state_t;

  typedef struct packed {
    logic [S_MAX-1:0]  e_raddr;
    logic              e_we_lk;
    logic              e_we_res;
    logic [S_MAX-1:0]  e_waddr;
    logic [L_MAX-1:0]  e_wlink;
    logic [N_MAX-1:0]  e_wdest;
    logic [C_MAX-1:0]  e_wres;
    logic [N_MAX-1:0]  h_raddr;
    logic              h_we;
    logic [N_MAX-1:0]  h_waddr;
    logic [L_MAX-1:0]  h_wdata;
    logic              h_clr;
    logic [N_MAX-1:0]  lv_raddr;
    logic              lv_we;
    logic [N_MAX-1:0]  lv_waddr;
    logic [LV_MAX-1:0] lv_wdata;
    logic [N_MAX-1:0]  a_raddr;
    logic              a_we;
    logic [N_MAX-1:0]  a_waddr;
    logic [L_MAX-1:0]  a_wdata;
    logic              a_clr;
    logic [N_MAX-1:0]  q_raddr;
    logic              q_we;
    logic [N_MAX-1:0]  q_waddr;
    logic [N_MAX-1:0]  q_wdata;
    logic [N_MAX-1:0]  p_raddr;
    logic              p_we;
    logic [N_MAX-1:0]  p_waddr;
    logic [S_MAX-1:0]  p_wdata;
    logic              m_clr;
    logic              m_set;
    logic [N_MAX-1:0]  m_addr;
    logic              kill;
    logic [N_MAX-1:0]  kill_addr;
    logic [N_MAX-1:0]  qa;
    logic [N_MAX-1:0]  qb;
  } dp_cmd_t;

  typedef struct packed {
    logic [L_MAX-1:0]  edge_next;
    logic [N_MAX-1:0]  edge_dest;
    logic [C_MAX-1:0]  edge_res;
    logic [L_MAX-1:0]  head;
    logic [LV_MAX-1:0] level;
    logic [L_MAX-1:0]  arc;
    logic [N_MAX-1:0]  queue;
    logic [S_MAX-1:0]  path;
    logic              vis_a;
    logic              vis_b;
    logic              live_a;
    logic              live_b;
  } dp_stat_t;

endpackage

// ===== hdl/mfd_req_if.sv =====
// request channel: valid, ready and one request word
interface mfd_req_if;
  logic        valid;
  logic        ready;
  logic [1:0]  req_type;
  logic [5:0]  node_a;
  logic [5:0]  node_b;
  logic [15:0] capacity;

  modport source (output valid, req_type, node_a, node_b, capacity, input ready);
  modport sink (input valid, req_type, node_a, node_b, capacity, output ready);
endinterface

// ===== hdl/mfd_rsp_if.sv =====
// result channel: valid, ready and one result word
interface mfd_rsp_if;
  logic        valid;
  logic        ready;
  logic [23:0] flow_total;
  logic [1:0]  status;

  modport source (output valid, flow_total, status, input ready);
  modport sink (input valid, flow_total, status, output ready);
endinterface

// ===== hdl/mfd_ram.sv =====
// generic single-write, single-read ram with registered read data
module mfd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

// ===== hdl/mfd_dp.sv =====
// datapath: edge store, adjacency heads, node work stores and mark bits
module mfd_dp #(
  parameter int NODES    = 64,
  parameter int EDGES    = 256,
  parameter int CAP_BITS = 16
) (
  input  logic              clk,
  input  logic              rst,
  input  mfd_pkg::dp_cmd_t  cmd,
  output mfd_pkg::dp_stat_t stat
);
  import mfd_pkg::*;

  localparam int SLOTS = 2 * EDGES;
  localparam int NW    = $clog2(NODES);
  localparam int SW    = $clog2(SLOTS);
  localparam int LW    = $clog2(SLOTS + 1);
  localparam int LVW   = $clog2(NODES);

  logic [LW-1:0]  nxt_q, head_q, arc_q;
  logic [NW-1:0]  dest_q, queue_q;
  logic [CAP_BITS-1:0] res_q;
  logic [LVW-1:0] level_q;
  logic [SW-1:0]  path_q;

  logic [NODES-1:0] head_vld, arc_vld, visited, live;
  logic hv_q, av_q;
  logic [LW-1:0] head_eff;

  mfd_ram #(.WIDTH(LW), .DEPTH(SLOTS)) u_next (
    .clk, .we(cmd.e_we_lk), .waddr(SW'(cmd.e_waddr)), .wdata(LW'(cmd.e_wlink)),
    .raddr(SW'(cmd.e_raddr)), .rdata(nxt_q));
  mfd_ram #(.WIDTH(NW), .DEPTH(SLOTS)) u_dest (
    .clk, .we(cmd.e_we_lk), .waddr(SW'(cmd.e_waddr)), .wdata(NW'(cmd.e_wdest)),
    .raddr(SW'(cmd.e_raddr)), .rdata(dest_q));
  mfd_ram #(.WIDTH(CAP_BITS), .DEPTH(SLOTS)) u_res (
    .clk, .we(cmd.e_we_res), .waddr(SW'(cmd.e_waddr)), .wdata(CAP_BITS'(cmd.e_wres)),
    .raddr(SW'(cmd.e_raddr)), .rdata(res_q));
  mfd_ram #(.WIDTH(LW), .DEPTH(NODES)) u_head (
    .clk, .we(cmd.h_we), .waddr(NW'(cmd.h_waddr)), .wdata(LW'(cmd.h_wdata)),
    .raddr(NW'(cmd.h_raddr)), .rdata(head_q));
  mfd_ram #(.WIDTH(LVW), .DEPTH(NODES)) u_level (
    .clk, .we(cmd.lv_we), .waddr(NW'(cmd.lv_waddr)), .wdata(LVW'(cmd.lv_wdata)),
    .raddr(NW'(cmd.lv_raddr)), .rdata(level_q));
  mfd_ram #(.WIDTH(LW), .DEPTH(NODES)) u_arc (
    .clk, .we(cmd.a_we), .waddr(NW'(cmd.a_waddr)), .wdata(LW'(cmd.a_wdata)),
    .raddr(NW'(cmd.a_raddr)), .rdata(arc_q));
  mfd_ram #(.WIDTH(NW), .DEPTH(NODES)) u_queue (
    .clk, .we(cmd.q_we), .waddr(NW'(cmd.q_waddr)), .wdata(NW'(cmd.q_wdata)),
    .raddr(NW'(cmd.q_raddr)), .rdata(queue_q));
  mfd_ram #(.WIDTH(SW), .DEPTH(NODES)) u_path (
    .clk, .we(cmd.p_we), .waddr(NW'(cmd.p_waddr)), .wdata(SW'(cmd.p_wdata)),
    .raddr(NW'(cmd.p_raddr)), .rdata(path_q));

  always_ff @(posedge clk) begin
    if (rst) begin
      head_vld <= '0;
      arc_vld  <= '0;
      visited  <= '0;
      live     <= '0;
      hv_q     <= 1'b0;
      av_q     <= 1'b0;
    end else begin
      hv_q <= head_vld[NW'(cmd.h_raddr)];
      av_q <= arc_vld[NW'(cmd.a_raddr)];
      if (cmd.h_clr) begin
        head_vld <= '0;
      end else if (cmd.h_we) begin
        head_vld[NW'(cmd.h_waddr)] <= 1'b1;
      end
      if (cmd.a_clr) begin
        arc_vld <= '0;
      end else if (cmd.a_we) begin
        arc_vld[NW'(cmd.a_waddr)] <= 1'b1;
      end
      if (cmd.m_clr) begin
        visited <= '0;
        live    <= '0;
      end
      if (cmd.m_set) begin
        visited[NW'(cmd.m_addr)] <= 1'b1;
        live[NW'(cmd.m_addr)]    <= 1'b1;
      end
      if (cmd.kill) begin
        live[NW'(cmd.kill_addr)] <= 1'b0;
      end
    end
  end

  assign head_eff = hv_q ? head_q : '0;

  always_comb begin
    stat.edge_next = L_MAX'(nxt_q);
    stat.edge_dest = N_MAX'(dest_q);
    stat.edge_res  = C_MAX'(res_q);
    stat.head      = L_MAX'(head_eff);
    stat.level     = LV_MAX'(level_q);
    stat.arc       = L_MAX'(av_q ? arc_q : head_eff);
    stat.queue     = N_MAX'(queue_q);
    stat.path      = S_MAX'(path_q);
    stat.vis_a     = visited[NW'(cmd.qa)];
    stat.vis_b     = visited[NW'(cmd.qb)];
    stat.live_a    = live[NW'(cmd.qa)];
    stat.live_b    = live[NW'(cmd.qb)];
  end
endmodule

// ===== hdl/mfd_ctrl.sv =====
// controller: request decode, level labelling and blocking-flow sequencer
module mfd_ctrl #(
  parameter int NODES    = 64,
  parameter int EDGES    = 256,
  parameter int CAP_BITS = 16
) (
  input  logic              clk,
  input  logic              rst,
  mfd_req_if.sink           req,
  mfd_rsp_if.source         rsp,
  output mfd_pkg::dp_cmd_t  cmd,
  input  mfd_pkg::dp_stat_t stat
);
  import mfd_pkg::*;

  localparam int SLOTS = 2 * EDGES;
  localparam int NW    = $clog2(NODES);
  localparam int SW    = $clog2(SLOTS);
  localparam int LW    = $clog2(SLOTS + 1);
  localparam int LVW   = $clog2(NODES);
  localparam int PLW   = $clog2(NODES + 1);
  localparam int CNTW  = $clog2(SLOTS + 1);
  localparam int CW    = CAP_BITS;

  state_t state, state_next;
  logic [1:0] rtype, rtype_next;
  logic [5:0] ra, ra_next, rb, rb_next;
  logic [CW-1:0] rcap, rcap_next;
  logic [CNTW-1:0] count, count_next;
  logic [PLW-1:0] rd, rd_next, wr, wr_next;
  logic [PLW-1:0] pl, pl_next, idx, idx_next, best, best_next;
  logic [LVW-1:0] lvu, lvu_next, lvx, lvx_next;
  logic [LW-1:0] link, link_next, nxt, nxt_next;
  logic [NW-1:0] x, x_next, v, v_next;
  logic [CW-1:0] res, res_next;
  logic [CW:0] delta, delta_next;
  logic [SW-1:0] eidx, eidx_next;
  logic [FLOW_BITS-1:0] flow, flow_next, oflow, oflow_next;
  logic [1:0] rstat, rstat_next, ostat, ostat_next;
  logic ov, ov_next;

  logic [NW-1:0] src, snk;
  logic a_ok, b_ok;
  logic [FLOW_BITS+CW:0] fsum;

  assign src  = NW'(ra);
  assign snk  = NW'(rb);
  assign a_ok = 32'(ra) < NODES;
  assign b_ok = 32'(rb) < NODES;
  assign fsum = (FLOW_BITS+CW+1)'(flow) + (FLOW_BITS+CW+1)'(delta[CW-1:0]);

  assign req.ready      = (state == S_IDLE);
  assign rsp.valid      = ov;
  assign rsp.flow_total = oflow;
  assign rsp.status     = ostat;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      count <= '0;
      pl    <= '0;
      ov    <= 1'b0;
    end else begin
      state <= state_next;
      count <= count_next;
      pl    <= pl_next;
      ov    <= ov_next;
    end
    rtype <= rtype_next;
    ra    <= ra_next;
    rb    <= rb_next;
    rcap  <= rcap_next;
    rd    <= rd_next;
    wr    <= wr_next;
    idx   <= idx_next;
    best  <= best_next;
    lvu   <= lvu_next;
    lvx   <= lvx_next;
    link  <= link_next;
    nxt   <= nxt_next;
    x     <= x_next;
    v     <= v_next;
    res   <= res_next;
    delta <= delta_next;
    eidx  <= eidx_next;
    flow  <= flow_next;
    rstat <= rstat_next;
    oflow <= oflow_next;
    ostat <= ostat_next;
  end

  always_comb begin
    state_next = state;
    rtype_next = rtype;
    ra_next    = ra;
    rb_next    = rb;
    rcap_next  = rcap;
    count_next = count;
    rd_next    = rd;
    wr_next    = wr;
    pl_next    = pl;
    idx_next   = idx;
    best_next  = best;
    lvu_next   = lvu;
    lvx_next   = lvx;
    link_next  = link;
    nxt_next   = nxt;
    x_next     = x;
    v_next     = v;
    res_next   = res;
    delta_next = delta;
    eidx_next  = eidx;
    flow_next  = flow;
    rstat_next = rstat;
    oflow_next = oflow;
    ostat_next = ostat;
    ov_next    = ov && !rsp.ready;
    cmd        = '0;

    case (state)
      S_IDLE: begin
        if (req.valid) begin
          rtype_next = req.req_type;
          ra_next    = req.node_a;
          rb_next    = req.node_b;
          rcap_next  = CW'(req.capacity);
          flow_next  = '0;
          rstat_next = ST_OK;
          state_next = S_DEC;
        end
      end
      S_DEC: begin
        state_next = S_DONE;
        case (rtype)
          REQ_CLEAR: begin
            cmd.h_clr  = 1'b1;
            count_next = '0;
          end
          REQ_ADD: begin
            if (a_ok && b_ok) begin
              if (32'(count) + 2 > SLOTS) begin
                rstat_next = ST_FULL;
              end else begin
                state_next = S_ADD_A;
              end
            end
          end
          REQ_RUN: begin
            if (ra == rb) begin
              rstat_next = ST_SAME;
            end else if (a_ok && b_ok) begin
              state_next = S_B_INIT;
            end
          end
          default: begin
          end
        endcase
      end
      S_ADD_A: begin
        cmd.h_raddr = N_MAX'(src);
        state_next  = S_ADD_B;
      end
      S_ADD_B: begin
        cmd.e_we_lk  = 1'b1;
        cmd.e_we_res = 1'b1;
        cmd.e_waddr  = S_MAX'(count);
        cmd.e_wlink  = stat.head;
        cmd.e_wdest  = N_MAX'(snk);
        cmd.e_wres   = C_MAX'(rcap);
        cmd.h_we     = 1'b1;
        cmd.h_waddr  = N_MAX'(src);
        cmd.h_wdata  = L_MAX'(LW'(count) + 1'b1);
        cmd.h_raddr  = N_MAX'(snk);
        state_next   = S_ADD_C;
      end
      S_ADD_C: begin
        cmd.e_we_lk  = 1'b1;
        cmd.e_we_res = 1'b1;
        cmd.e_waddr  = S_MAX'(SW'(count) | SW'(1));
        cmd.e_wlink  = (ra == rb) ? L_MAX'(LW'(count) + 1'b1) : stat.head;
        cmd.e_wdest  = N_MAX'(src);
        cmd.e_wres   = '0;
        cmd.h_we     = 1'b1;
        cmd.h_waddr  = N_MAX'(snk);
        cmd.h_wdata  = L_MAX'(LW'(count) + LW'(2));
        count_next   = count + CNTW'(2);
        state_next   = S_DONE;
      end
      S_B_INIT: begin
        cmd.m_clr    = 1'b1;
        cmd.m_set    = 1'b1;
        cmd.m_addr   = N_MAX'(src);
        cmd.lv_we    = 1'b1;
        cmd.lv_waddr = N_MAX'(src);
        cmd.lv_wdata = '0;
        cmd.q_we     = 1'b1;
        cmd.q_waddr  = '0;
        cmd.q_wdata  = N_MAX'(src);
        rd_next      = '0;
        wr_next      = PLW'(1);
        state_next   = S_B_POP;
      end
      S_B_POP: begin
        cmd.qa = N_MAX'(snk);
        if (stat.vis_a) begin
          state_next = S_F_INIT;
        end else if (rd < wr) begin
          cmd.q_raddr = N_MAX'(NW'(rd));
          rd_next     = rd + 1'b1;
          state_next  = S_B_POPW;
        end else begin
          state_next = S_DONE;
        end
      end
      S_B_POPW: begin
        cmd.h_raddr  = stat.queue;
        cmd.lv_raddr = stat.queue;
        state_next   = S_B_HEAD;
      end
      S_B_HEAD: begin
        link_next  = LW'(stat.head);
        lvu_next   = LVW'(stat.level);
        state_next = S_B_EDGE;
      end
      S_B_EDGE: begin
        if (link == '0) begin
          state_next = S_B_POP;
        end else begin
          cmd.e_raddr = S_MAX'(link - 1'b1);
          state_next  = S_B_EDGEW;
        end
      end
      S_B_EDGEW: begin
        cmd.qb = stat.edge_dest;
        if (!stat.vis_b && stat.edge_res != '0 && 32'(wr) < NODES) begin
          cmd.q_we     = 1'b1;
          cmd.q_waddr  = N_MAX'(NW'(wr));
          cmd.q_wdata  = stat.edge_dest;
          cmd.m_set    = 1'b1;
          cmd.m_addr   = stat.edge_dest;
          cmd.lv_we    = 1'b1;
          cmd.lv_waddr = stat.edge_dest;
          cmd.lv_wdata = LV_MAX'(LVW'(lvu + 1'b1));
          wr_next      = wr + 1'b1;
        end
        link_next  = LW'(stat.edge_next);
        state_next = S_B_EDGE;
      end
      S_F_INIT: begin
        cmd.a_clr  = 1'b1;
        pl_next    = '0;
        x_next     = src;
        state_next = S_F_TOP;
      end
      S_F_TOP: begin
        if (x == snk) begin
          idx_next   = '0;
          best_next  = '0;
          delta_next = '1;
          state_next = S_P_RD;
        end else begin
          state_next = S_F_ARC;
        end
      end
      S_F_ARC: begin
        cmd.a_raddr  = N_MAX'(x);
        cmd.h_raddr  = N_MAX'(x);
        cmd.lv_raddr = N_MAX'(x);
        state_next   = S_F_ARCW;
      end
      S_F_ARCW: begin
        link_next  = LW'(stat.arc);
        lvx_next   = LVW'(stat.level);
        state_next = S_N_CHK;
      end
      S_N_CHK: begin
        if (link == '0) begin
          state_next = S_N_RES;
        end else begin
          cmd.e_raddr = S_MAX'(link - 1'b1);
          state_next  = S_N_W;
        end
      end
      S_N_W: begin
        v_next       = NW'(stat.edge_dest);
        res_next     = CW'(stat.edge_res);
        nxt_next     = LW'(stat.edge_next);
        cmd.lv_raddr = stat.edge_dest;
        state_next   = S_N_W2;
      end
      S_N_W2: begin
        cmd.qa = N_MAX'(x);
        cmd.qb = N_MAX'(v);
        if (res != '0 && stat.live_a && stat.live_b &&
            {1'b0, LVW'(stat.level)} == {1'b0, lvx} + 1'b1) begin
          state_next = S_N_RES;
        end else begin
          link_next  = nxt;
          state_next = S_N_CHK;
        end
      end
      S_N_RES: begin
        cmd.a_we    = 1'b1;
        cmd.a_waddr = N_MAX'(x);
        cmd.a_wdata = L_MAX'(link);
        if (link == '0) begin
          if (pl == '0) begin
            state_next = S_B_INIT;
          end else begin
            cmd.kill      = 1'b1;
            cmd.kill_addr = N_MAX'(x);
            pl_next       = pl - 1'b1;
            state_next    = S_E_RD;
          end
        end else if (32'(pl) >= NODES) begin
          state_next = S_B_INIT;
        end else begin
          cmd.p_we    = 1'b1;
          cmd.p_waddr = N_MAX'(NW'(pl));
          cmd.p_wdata = S_MAX'(link - 1'b1);
          pl_next     = pl + 1'b1;
          x_next      = v;
          state_next  = S_F_TOP;
        end
      end
      S_E_RD: begin
        if (pl == '0) begin
          x_next     = src;
          state_next = S_F_TOP;
        end else begin
          cmd.p_raddr = N_MAX'(NW'(pl - 1'b1));
          state_next  = S_E_W1;
        end
      end
      S_E_W1: begin
        cmd.e_raddr = stat.path;
        state_next  = S_E_W2;
      end
      S_E_W2: begin
        x_next     = NW'(stat.edge_dest);
        state_next = S_F_TOP;
      end
      S_P_RD: begin
        if (idx < pl) begin
          cmd.p_raddr = N_MAX'(NW'(idx));
          state_next  = S_P_RDW;
        end else begin
          idx_next   = '0;
          state_next = S_Q_RD;
        end
      end
      S_P_RDW: begin
        cmd.e_raddr = stat.path;
        state_next  = S_P_CMP;
      end
      S_P_CMP: begin
        if ({1'b0, CW'(stat.edge_res)} < delta) begin
          delta_next = {1'b0, CW'(stat.edge_res)};
          best_next  = idx;
        end
        idx_next   = idx + 1'b1;
        state_next = S_P_RD;
      end
      S_Q_RD: begin
        if (idx < pl) begin
          cmd.p_raddr = N_MAX'(NW'(idx));
          state_next  = S_Q_W1;
        end else begin
          pl_next    = best;
          flow_next  = (fsum > (FLOW_BITS+CW+1)'(FLOW_MAX)) ? FLOW_MAX : FLOW_BITS'(fsum);
          state_next = S_E_RD;
        end
      end
      S_Q_W1: begin
        eidx_next   = SW'(stat.path);
        cmd.e_raddr = stat.path;
        state_next  = S_Q_W2;
      end
      S_Q_W2: begin
        cmd.e_we_res = 1'b1;
        cmd.e_waddr  = S_MAX'(eidx);
        cmd.e_wres   = C_MAX'(CW'(stat.edge_res) - delta[CW-1:0]);
        cmd.e_raddr  = S_MAX'(eidx ^ SW'(1));
        state_next   = S_Q_W3;
      end
      S_Q_W3: begin
        cmd.e_we_res = 1'b1;
        cmd.e_waddr  = S_MAX'(eidx ^ SW'(1));
        cmd.e_wres   = C_MAX'(CW'(stat.edge_res) + delta[CW-1:0]);
        idx_next     = idx + 1'b1;
        state_next   = S_Q_RD;
      end
      S_DONE: begin
        if (!ov || rsp.ready) begin
          ov_next    = 1'b1;
          oflow_next = flow;
          ostat_next = rstat;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end
endmodule

// ===== hdl/max_flow_dinic_core.sv =====
// top level of the max-flow engine: controller plus datapath
// usage:
//   req carries one request word: req_type, node_a, node_b, capacity.
//   rsp returns exactly one word per request: flow_total and status.
//   a clear resets the heads and the edge count; an add edge writes
//   the forward slot, then the reverse slot. a run takes a
//   data-dependent time: queue pops and scanned edges in each level
//   pass, then forward arc steps, skipped edges, retreats and path
//   entries in each augmentation.
//   the controller sequences single-port reads of the edge store, so
//   one request is in work at a time; req.ready is high while idle.
//   the result sits in an output register; a new request is accepted
//   while it waits, and a finished result holds until rsp.ready.
//   rst (synchronous) empties the graph, clears the edge count and
//   drops any pending result; no clearing pass is needed.
//   residual capacities stay in the store after a run.
module max_flow_dinic_core #(
  parameter int NODES    = 64,
  parameter int EDGES    = 256,
  parameter int CAP_BITS = 16
) (
  input logic       clk,
  input logic       rst,
  mfd_req_if.sink   req,
  mfd_rsp_if.source rsp
);
  import mfd_pkg::*;

  dp_cmd_t  cmd;
  dp_stat_t stat;

  mfd_ctrl #(.NODES(NODES), .EDGES(EDGES), .CAP_BITS(CAP_BITS)) u_ctrl (
    .clk, .rst, .req, .rsp, .cmd, .stat);

  mfd_dp #(.NODES(NODES), .EDGES(EDGES), .CAP_BITS(CAP_BITS)) u_dp (
    .clk, .rst, .cmd, .stat);
endmodule

// ===== sim/max_flow_dinic_core_test.sv =====
// testbench for the max-flow engine: directed table, random graphs, scoreboard against a predictor
module max_flow_dinic_core_test;
  import mfd_pkg::*;

  localparam int NODES = 64;
  localparam int EDGES = 256;
  localparam int SLOTS = 2 * EDGES;
  localparam int INF_CAP = 32'h3f3f3f3f;
  localparam int LIMIT = 20000000;
  localparam logic [1:0] REQ_SPARE = 2'd3;

  typedef struct {
    logic [1:0]  rq;
    logic [5:0]  a;
    logic [5:0]  b;
    logic [15:0] cap;
    bit          chk;
    logic [23:0] fl;
    logic [1:0]  st;
  } request_t;

  typedef struct {
    logic [23:0] fl;
    logic [1:0]  st;
  } result_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  mfd_req_if req ();
  mfd_rsp_if rsp ();

  max_flow_dinic_core i_dut (.clk(clk), .rst(rst), .req(req), .rsp(rsp));

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  request_t requests[$];
  result_t  pending_results[$];
  int       errors = 0;
  int       cycles = 0;
  int       words_out = 0;
  bit       quiet = 1'b0;

  // graph shadow
  int  e_next[SLOTS];
  int  e_dest[SLOTS];
  int  e_res[SLOTS];
  int  head[NODES];
  int  e_count;
  int  lvl[NODES];
  bit  live[NODES];
  bit  seen[NODES];
  int  arc[NODES];
  int  bq[NODES];
  int  path[NODES];
  int  plen;

  function automatic void label_levels(int s, int t);
    int rd, wr, u, link, e, v;
    rd = 0;
    wr = 0;
    for (int i = 0; i < NODES; i++) begin
      seen[i] = 0;
      live[i] = 0;
    end
    bq[wr++] = s;
    seen[s] = 1;
    live[s] = 1;
    lvl[s] = 0;
    while (rd < wr && !seen[t]) begin
      u = bq[rd++];
      link = head[u];
      while (link != 0) begin
        e = link - 1;
        v = e_dest[e];
        if (!seen[v] && e_res[e] > 0 && wr < NODES) begin
          bq[wr++] = v;
          seen[v] = 1;
          live[v] = 1;
          lvl[v] = lvl[u] + 1;
        end
        link = e_next[e];
      end
    end
  endfunction

  function automatic int push_bottleneck();
    int best, delta, e;
    best = 0;
    delta = INF_CAP;
    for (int i = 0; i < plen; i++)
      if (e_res[path[i]] < delta) begin
        delta = e_res[path[i]];
        best = i;
      end
    for (int i = 0; i < plen; i++) begin
      e = path[i];
      e_res[e] -= delta;
      e_res[e ^ 1] += delta;
    end
    plen = best;
    return delta;
  endfunction

  function automatic int path_tip(int s);
    if (plen != 0) return e_dest[path[plen-1]];
    return s;
  endfunction

  function automatic int usable_arc(int x);
    int link, e, v;
    link = arc[x];
    while (link != 0) begin
      e = link - 1;
      v = e_dest[e];
      if (e_res[e] != 0 && live[x] && live[v] && lvl[v] == lvl[x] + 1) return link;
      link = e_next[e];
    end
    return 0;
  endfunction

  function automatic longint blocking_flow(int s, int t);
    longint sum;
    int x, link;
    sum = 0;
    x = s;
    plen = 0;
    for (int i = 0; i < NODES; i++) arc[i] = head[i];
    forever begin
      if (x == t) begin
        sum += push_bottleneck();
        x = path_tip(s);
      end
      link = usable_arc(x);
      arc[x] = link;
      if (link == 0) begin
        if (plen == 0) break;
        live[x] = 0;
        plen--;
        x = path_tip(s);
        continue;
      end
      if (plen >= NODES) break;
      path[plen++] = link - 1;
      x = e_dest[link-1];
    end
    return sum;
  endfunction

  function automatic result_t predict_result(request_t r);
    result_t o;
    longint flow;
    int e;
    flow = 0;
    o.st = ST_OK;
    case (r.rq)
      REQ_CLEAR: begin
        e_count = 0;
        for (int i = 0; i < NODES; i++) head[i] = 0;
      end
      REQ_ADD: begin
        if (e_count + 2 > SLOTS) o.st = ST_FULL;
        else begin
          e = e_count;
          e_next[e] = head[r.a];
          e_dest[e] = int'(r.b);
          e_res[e] = int'(r.cap);
          head[r.a] = e + 1;
          e_next[e+1] = head[r.b];
          e_dest[e+1] = int'(r.a);
          e_res[e+1] = 0;
          head[r.b] = e + 2;
          e_count = e + 2;
        end
      end
      REQ_RUN: begin
        if (r.a == r.b) o.st = ST_SAME;
        else forever begin
          label_levels(int'(r.a), int'(r.b));
          if (!seen[r.b]) break;
          flow += blocking_flow(int'(r.a), int'(r.b));
          if (flow > FLOW_MAX) flow = FLOW_MAX;
        end
      end
      default: ;
    endcase
    o.fl = flow[23:0];
    return o;
  endfunction

  function automatic request_t mk(logic [1:0] rq, int a, int b, int cap);
    request_t r;
    r.rq = rq;
    r.a = 6'(a);
    r.b = 6'(b);
    r.cap = 16'(cap);
    r.chk = 0;
    r.fl = '0;
    r.st = ST_OK;
    return r;
  endfunction

  function automatic request_t mk_exp(logic [1:0] rq, int a, int b, int cap, int fl,
                                      logic [1:0] st);
    request_t r;
    r = mk(rq, a, b, cap);
    r.chk = 1;
    r.fl = 24'(fl);
    r.st = st;
    return r;
  endfunction

  function automatic int rand_cap();
    case ($urandom_range(0, 3))
      0: return $urandom_range(0, 65535);
      1: return $urandom_range(0, 3) == 0 ? 0 : 65535;
      default: return $urandom_range(0, 20);
    endcase
  endfunction

  task automatic build_requests();
    int base, span, nadd, nrun, a, b;
    bit big_done;
    big_done = 0;
    requests.push_back(mk_exp(REQ_RUN, 0, 1, 0, 0, ST_OK));
    requests.push_back(mk_exp(REQ_SPARE, 63, 63, 65535, 0, ST_OK));
    requests.push_back(mk_exp(REQ_RUN, 5, 5, 0, 0, ST_SAME));
    requests.push_back(mk_exp(REQ_ADD, 0, 63, 65535, 0, ST_OK));
    requests.push_back(mk_exp(REQ_ADD, 63, 0, 0, 0, ST_OK));
    requests.push_back(mk_exp(REQ_RUN, 0, 63, 0, 65535, ST_OK));
    requests.push_back(mk_exp(REQ_RUN, 0, 63, 0, 0, ST_OK));
    requests.push_back(mk(REQ_RUN, 63, 0, 65535));
    requests.push_back(mk_exp(REQ_CLEAR, 0, 0, 0, 0, ST_OK));
    requests.push_back(mk_exp(REQ_RUN, 0, 63, 0, 0, ST_OK));
    requests.push_back(mk(REQ_ADD, 1, 2, 10));
    requests.push_back(mk(REQ_ADD, 2, 3, 7));
    requests.push_back(mk(REQ_ADD, 1, 3, 5));
    requests.push_back(mk(REQ_RUN, 1, 3, 0));
    requests.push_back(mk_exp(REQ_RUN, 3, 3, 12345, 0, ST_SAME));
    requests.push_back(mk_exp(REQ_CLEAR, 63, 42, 65535, 0, ST_OK));
    requests.push_back(mk(REQ_ADD, 42, 21, 16'hAAAA));
    requests.push_back(mk(REQ_ADD, 21, 42, 16'h5555));
    requests.push_back(mk(REQ_RUN, 42, 21, 0));
    requests.push_back(mk(REQ_RUN, 21, 42, 0));
    while (requests.size() < 1700) begin
      if (!big_done && requests.size() > 700) begin
        // fill the edge store with parallel full edges, then overflow it
        big_done = 1;
        requests.push_back(mk(REQ_CLEAR, 0, 0, 0));
        for (int i = 0; i < EDGES; i++) requests.push_back(mk(REQ_ADD, 0, 63, 65535));
        requests.push_back(mk_exp(REQ_ADD, 0, 63, 65535, 0, ST_FULL));
        requests.push_back(mk_exp(REQ_ADD, 1, 2, 1, 0, ST_FULL));
        requests.push_back(mk_exp(REQ_RUN, 0, 63, 0, 16776960, ST_OK));
        requests.push_back(mk_exp(REQ_RUN, 0, 63, 0, 0, ST_OK));
        requests.push_back(mk(REQ_RUN, 63, 0, 0));
        continue;
      end
      span = $urandom_range(2, 8);
      base = $urandom_range(0, 64 - span);
      requests.push_back(mk(REQ_CLEAR, $urandom_range(0, 63), $urandom_range(0, 63),
                            $urandom_range(0, 65535)));
      nadd = $urandom_range(1, 14);
      for (int i = 0; i < nadd; i++) begin
        if ($urandom_range(0, 15) == 0)
          requests.push_back(mk(2'($urandom_range(0, 3)), $urandom_range(0, 63),
                                $urandom_range(0, 63), $urandom_range(0, 65535)));
        else
          requests.push_back(mk(REQ_ADD, base + $urandom_range(0, span - 1),
                                base + $urandom_range(0, span - 1), rand_cap()));
      end
      nrun = $urandom_range(1, 3);
      for (int i = 0; i < nrun; i++) begin
        a = base + $urandom_range(0, span - 1);
        b = $urandom_range(0, 7) == 0 ? a : base + $urandom_range(0, span - 1);
        requests.push_back(mk(REQ_RUN, a, b, $urandom_range(0, 65535)));
      end
    end
  endtask

  // request side
  initial begin
    int gap;
    req.valid = 1'b0;
    req.req_type = REQ_CLEAR;
    req.node_a = '0;
    req.node_b = '0;
    req.capacity = '0;
    build_requests();
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    for (int n = 0; n < requests.size(); n++) begin
      if (n > requests.size() * 85 / 100) quiet = 1'b1;
      if (!quiet && $urandom_range(0, 3) == 0) begin
        gap = $urandom_range(1, 8);
        req.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      req.valid <= 1'b1;
      req.req_type <= requests[n].rq;
      req.node_a <= requests[n].a;
      req.node_b <= requests[n].b;
      req.capacity <= requests[n].cap;
      @(posedge clk);
      while (!req.ready) @(posedge clk);
    end
    req.valid <= 1'b0;
    while (words_out < requests.size()) @(posedge clk);
    repeat (200) @(posedge clk);
    if (errors == 0) $display("max_flow_dinic_core_test: clean");
    else $display("max_flow_dinic_core_test: errors");
    $finish;
  end

  // predictor runs on each accepted request word
  int req_index = 0;
  always @(posedge clk) begin
    request_t r;
    result_t  p;
    if (!rst && req.valid && req.ready) begin
      r = requests[req_index];
      req_index++;
      p = predict_result(r);
      if (r.chk) begin
        p.fl = r.fl;
        p.st = r.st;
      end
      pending_results.push_back(p);
    end
  end

  // result side with random stalls and one long hold-off
  initial begin
    int stall;
    bit held;
    held = 0;
    rsp.ready = 1'b0;
    @(negedge rst);
    forever begin
      if (!held && words_out >= 300) begin
        held = 1;
        rsp.ready <= 1'b0;
        repeat (400) @(posedge clk);
      end else if (!quiet && $urandom_range(0, 5) == 0) begin
        stall = $urandom_range(1, 8);
        rsp.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end else begin
        rsp.ready <= 1'b1;
        @(posedge clk);
      end
    end
  end

  always @(posedge clk) begin
    result_t x;
    if (!rst && rsp.valid && rsp.ready) begin
      words_out++;
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected word flow %0d status %0d", $time, rsp.flow_total,
                 rsp.status);
        errors++;
      end else begin
        x = pending_results.pop_front();
        if (rsp.flow_total !== x.fl) begin
          $display("%0t: flow_total expected %0d actual %0d", $time, x.fl, rsp.flow_total);
          errors++;
        end
        if (rsp.status !== x.st) begin
          $display("%0t: status expected %0d actual %0d", $time, x.st, rsp.status);
          errors++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("max_flow_dinic_core_test: errors");
      $finish;
    end
  end

endmodule
